FILE: rtl/core/acf_pkg.sv
// Shared types, constants and tables for the adaptive complementary filter.
package acf_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;
  localparam int QUEUE_DEPTH      = 2;

  localparam int PI_Q      = 51472;
  localparam int TWO_PI_Q  = 102944;
  localparam int HALF_PI_Q = 25736;
  localparam int ONE_G     = 16384;

  localparam logic [24:0] DEG_TO_RAD_Q30 = 25'd18740330;
  localparam logic [27:0] HALF_PI_Z      = 28'd26353589;

  localparam logic [15:0] RST_PERIOD   = 16'd655;
  localparam logic [14:0] RST_ERR_LO   = 15'd819;
  localparam logic [14:0] RST_ERR_HI   = 15'd2458;
  localparam logic [15:0] RST_G_STEADY = 16'd58982;
  localparam logic [15:0] RST_G_MIDDLE = 16'd62259;
  localparam logic [15:0] RST_G_DYN    = 16'd64553;

  localparam logic [1:0] CLS_STEADY  = 2'd0;
  localparam logic [1:0] CLS_MIDDLE  = 2'd1;
  localparam logic [1:0] CLS_DYNAMIC = 2'd2;

  typedef enum logic [2:0] {
    REG_PERIOD   = 3'd0,
    REG_ERR_LO   = 3'd1,
    REG_ERR_HI   = 3'd2,
    REG_G_STEADY = 3'd3,
    REG_G_MIDDLE = 3'd4,
    REG_G_DYN    = 3'd5
  } acf_reg_t;

  typedef struct packed {
    logic [15:0] period;
    logic [14:0] err_lo;
    logic [14:0] err_hi;
    logic [15:0] g_steady;
    logic [15:0] g_middle;
    logic [15:0] g_dynamic;
  } acf_cfg_t;

  typedef struct packed {
    logic signed [15:0] rate;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [31:0]        ax2;
    logic [31:0]        ay2;
    logic [31:0]        az2;
  } acf_item_t;

  // atan(2^-i) in 1/2^24 rad
  function automatic logic [23:0] atan_entry(input logic [4:0] i);
    logic [23:0] v;
    case (i)
      5'd0:  v = 24'd13176795;
      5'd1:  v = 24'd7778716;
      5'd2:  v = 24'd4110060;
      5'd3:  v = 24'd2086331;
      5'd4:  v = 24'd1047214;
      5'd5:  v = 24'd524117;
      5'd6:  v = 24'd262123;
      5'd7:  v = 24'd131069;
      5'd8:  v = 24'd65536;
      5'd9:  v = 24'd32768;
      5'd10: v = 24'd16384;
      5'd11: v = 24'd8192;
      5'd12: v = 24'd4096;
      5'd13: v = 24'd2048;
      5'd14: v = 24'd1024;
      5'd15: v = 24'd512;
      5'd16: v = 24'd256;
      5'd17: v = 24'd128;
      5'd18: v = 24'd64;
      5'd19: v = 24'd32;
      5'd20: v = 24'd16;
      5'd21: v = 24'd8;
      5'd22: v = 24'd4;
      5'd23: v = 24'd2;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/acf_if.sv
// Channel interfaces: sample input, result output, register write.
interface acf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rate_roll;
  logic signed [15:0] accel_fwd;
  logic signed [15:0] accel_side;
  logic signed [15:0] accel_vert;
  modport source (output valid, rate_roll, accel_fwd, accel_side, accel_vert, input ready);
  modport sink   (input valid, rate_roll, accel_fwd, accel_side, accel_vert, output ready);
endinterface

interface acf_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] roll_estimate;
  logic signed [15:0] pitch_estimate;
  logic [1:0]         gain_class;
  modport source (output valid, roll_estimate, pitch_estimate, gain_class, input ready);
  modport sink   (input valid, roll_estimate, pitch_estimate, gain_class, output ready);
endinterface

interface acf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/acf_front.sv
// Front end: accepts samples, squares the accel axes, hands words to the queue.
module acf_front (
  input  logic              clk,
  input  logic              rst_n,
  acf_in_if.sink            in_ch,
  output logic              push,
  input  logic              full,
  output acf_pkg::acf_item_t item
);

  logic               stv_r;
  acf_pkg::acf_item_t stage_r;
  logic               acc;
  logic signed [31:0] sx, sy, sz;

  assign push        = stv_r && !full;
  assign in_ch.ready = !stv_r || !full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign item        = stage_r;

  // widen before squaring so the product is formed at full width
  assign sx = 32'(in_ch.accel_fwd);
  assign sy = 32'(in_ch.accel_side);
  assign sz = 32'(in_ch.accel_vert);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stv_r <= 1'b0;
    end else if (acc) begin
      stv_r <= 1'b1;
    end else if (push) begin
      stv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      stage_r.rate <= in_ch.rate_roll;
      stage_r.ax   <= in_ch.accel_fwd;
      stage_r.ay   <= in_ch.accel_side;
      stage_r.az   <= in_ch.accel_vert;
      stage_r.ax2  <= 32'(sx * sx);
      stage_r.ay2  <= 32'(sy * sy);
      stage_r.az2  <= 32'(sz * sz);
    end
  end

endmodule

FILE: rtl/core/acf_fifo.sv
// Short queue between front and back end.
module acf_fifo #(
  parameter int DEPTH = acf_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  acf_pkg::acf_item_t wdata,
  output logic               full,
  input  logic               pop,
  output logic               nempty,
  output acf_pkg::acf_item_t rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  acf_pkg::acf_item_t mem [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign full   = (cnt_r == (PW+1)'(DEPTH));
  assign nempty = (cnt_r != '0);
  assign rdata  = mem[rp_r];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH-1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= bump(wp_r);
      if (pop)  rp_r <= bump(rp_r);
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wdata;
  end

endmodule

FILE: rtl/core/acf_back.sv
// Back end: gyro integration, shared sqrt, shared CORDIC, gain pick, blend, wrap.
module acf_back #(
  parameter int CORDIC_STEPS = acf_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  acf_pkg::acf_cfg_t  cfg,
  input  logic               q_nempty,
  input  acf_pkg::acf_item_t q_item,
  output logic               q_pop,
  acf_out_if.source          out_ch
);

  localparam int CSTEPS = (CORDIC_STEPS < acf_pkg::ATAN_LEN) ? CORDIC_STEPS : acf_pkg::ATAN_LEN;

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001, S_MUL1 = 15'h0002, S_MUL2 = 15'h0004, S_GINC = 15'h0008,
    S_SQM  = 15'h0010, S_CLS  = 15'h0020, S_CRD  = 15'h0040, S_CRF  = 15'h0080,
    S_SQS  = 15'h0100, S_LDP  = 15'h0200, S_CPD  = 15'h0400, S_CPF  = 15'h0800,
    S_BL2  = 15'h1000, S_BL3  = 15'h2000, S_WRAP = 15'h4000
  } st_t;

  st_t                state_r;
  logic               ostate_r;  // waiting to load the output register
  acf_pkg::acf_item_t item_r;
  logic signed [32:0] p1_r;
  logic signed [58:0] p2_r;
  logic signed [23:0] gyro_r;
  logic signed [16:0] roll_held_r;
  logic [59:0]        rad_r;
  logic [33:0]        rem_r;
  logic [29:0]        root_r;
  logic [4:0]         cnt_r;
  logic [1:0]         cls_r;
  logic [15:0]        g_r;
  logic signed [33:0] cx_r, cy_r;
  logic signed [27:0] cz_r;
  logic               czero_r;
  logic signed [16:0] aroll_r;
  logic signed [15:0] pitch_r;
  logic signed [40:0] m1_r;
  logic signed [34:0] m2_r;
  logic signed [25:0] blend_r;
  logic               ov_r;
  logic signed [16:0] oroll_r;
  logic signed [15:0] opitch_r;
  logic [1:0]         ocls_r;

  // sqrt step
  logic [33:0] sq_rem2, sq_trial;
  always_comb begin
    sq_rem2  = {rem_r[31:0], rad_r[59:58]};
    sq_trial = {2'b00, root_r, 2'b01};
  end

  // CORDIC step
  logic signed [33:0] dx, dy;
  logic signed [27:0] at;
  always_comb begin
    dx = cy_r >>> cnt_r;
    dy = cx_r >>> cnt_r;
    at = $signed({4'b0000, acf_pkg::atan_entry(cnt_r)});
  end

  // operand load with quadrant fold
  logic signed [33:0] ly, lx, px, py;
  logic signed [27:0] pz;
  logic               pzero;
  always_comb begin
    if (state_r == S_CLS) begin
      ly = $signed({{4{item_r.ay[15]}}, item_r.ay, 14'b0});
      lx = $signed({{4{item_r.az[15]}}, item_r.az, 14'b0});
    end else begin
      ly = -$signed({{4{item_r.ax[15]}}, item_r.ax, 14'b0});
      lx = $signed({4'b0000, root_r});
    end
    pzero = (lx == '0) && (ly == '0);
    if (lx < 0) begin
      if (ly >= 0) begin
        px = ly; py = -lx; pz = $signed(acf_pkg::HALF_PI_Z);
      end else begin
        px = -ly; py = lx; pz = -$signed(acf_pkg::HALF_PI_Z);
      end
    end else begin
      px = lx; py = ly; pz = '0;
    end
  end

  // angle rounding to 1/16384 rad, half away from zero
  logic [27:0]        za;
  logic [17:0]        zr;
  logic signed [18:0] zs;
  logic signed [16:0] zclamp_pi;
  logic signed [15:0] zclamp_hp;
  always_comb begin
    za = cz_r[27] ? 28'(-cz_r) : 28'(cz_r);
    zr = 18'((za + 28'd512) >> 10);
    zs = cz_r[27] ? -$signed({1'b0, zr}) : $signed({1'b0, zr});
    if (czero_r) zs = '0;
    if (zs > 19'sd51472) zclamp_pi = 17'sd51472;
    else if (zs < -19'sd51472) zclamp_pi = -17'sd51472;
    else zclamp_pi = 17'(zs);
    if (zs > 19'sd25736) zclamp_hp = 16'sd25736;
    else if (zs < -19'sd25736) zclamp_hp = -16'sd25736;
    else zclamp_hp = 16'(zs);
  end

  // gyro increment rounding
  logic [58:0]        pa;
  logic [22:0]        pr;
  logic signed [23:0] ginc;
  always_comb begin
    pa   = p2_r[58] ? 59'(-p2_r) : 59'(p2_r);
    pr   = 23'((pa + (59'd1 << 35)) >> 36);
    ginc = p2_r[58] ? -$signed({1'b0, pr}) : $signed({1'b0, pr});
  end

  // magnitude error and gain pick
  logic [15:0] mag;
  logic [16:0] err;
  logic [1:0]  cls_n;
  logic [15:0] g_n;
  always_comb begin
    mag = root_r[15:0];
    err = (mag >= 16'(acf_pkg::ONE_G)) ? 17'(mag - 16'(acf_pkg::ONE_G))
                                       : 17'(16'(acf_pkg::ONE_G) - mag);
    if (err < {2'b00, cfg.err_lo}) begin
      cls_n = acf_pkg::CLS_STEADY;  g_n = cfg.g_steady;
    end else if (err < {2'b00, cfg.err_hi}) begin
      cls_n = acf_pkg::CLS_MIDDLE;  g_n = cfg.g_middle;
    end else begin
      cls_n = acf_pkg::CLS_DYNAMIC; g_n = cfg.g_dynamic;
    end
  end

  // blend rounding
  logic signed [41:0] bsum;
  logic [41:0]        ba;
  logic [25:0]        br;
  logic [16:0]        ginv;
  always_comb begin
    bsum = 42'(m1_r) + 42'(m2_r);
    ba   = bsum[41] ? 42'(-bsum) : 42'(bsum);
    br   = 26'((ba + 42'd32768) >> 16);
    ginv = 17'(17'd65536 - {1'b0, g_r});
  end

  assign q_pop = (state_r == S_IDLE) && !ostate_r && q_nempty;

  logic load_out;
  assign load_out = ostate_r && (!ov_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ostate_r    <= 1'b0;
      ov_r        <= 1'b0;
      roll_held_r <= '0;
    end else begin
      if (load_out) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
      if (load_out) ostate_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (q_pop) state_r <= S_MUL1;
        S_MUL1: state_r <= S_MUL2;
        S_MUL2: state_r <= S_GINC;
        S_GINC: state_r <= S_SQM;
        S_SQM:  if (cnt_r == 5'd1) state_r <= S_CLS;
        S_CLS:  state_r <= S_CRD;
        S_CRD:  if (cnt_r == 5'(CSTEPS-1)) state_r <= S_CRF;
        S_CRF:  state_r <= S_SQS;
        S_SQS:  if (cnt_r == 5'd1) state_r <= S_LDP;
        S_LDP:  state_r <= S_CPD;
        S_CPD:  if (cnt_r == 5'(CSTEPS-1)) state_r <= S_CPF;
        S_CPF:  state_r <= S_BL2;
        S_BL2:  state_r <= S_BL3;
        S_BL3:  state_r <= S_WRAP;
        S_WRAP: begin
          if (blend_r <= 26'sd51472 && blend_r >= -26'sd51472) begin
            roll_held_r <= 17'(blend_r);
            ostate_r    <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (q_pop) item_r <= q_item;
      S_MUL1: begin
        p1_r   <= item_r.rate * $signed({1'b0, cfg.period});
        rad_r  <= {item_r.ax2 + item_r.ay2 + item_r.az2, 28'b0};
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= 5'd16;
      end
      S_MUL2: p2_r <= p1_r * $signed({1'b0, acf_pkg::DEG_TO_RAD_Q30});
      S_GINC: gyro_r <= 24'(roll_held_r) + ginc;
      S_SQM, S_SQS: begin
        if (sq_rem2 >= sq_trial) begin
          rem_r  <= sq_rem2 - sq_trial;
          root_r <= {root_r[28:0], 1'b1};
        end else begin
          rem_r  <= sq_rem2;
          root_r <= {root_r[28:0], 1'b0};
        end
        rad_r <= {rad_r[57:0], 2'b00};
        cnt_r <= cnt_r - 1'b1;
      end
      S_CLS, S_LDP: begin
        if (state_r == S_CLS) begin
          cls_r <= cls_n;
          g_r   <= g_n;
        end
        cx_r    <= px;
        cy_r    <= py;
        cz_r    <= pz;
        czero_r <= pzero;
        cnt_r   <= '0;
      end
      S_CRD, S_CPD: begin
        if (cy_r > 0) begin
          cx_r <= cx_r + dx; cy_r <= cy_r - dy; cz_r <= cz_r + at;
        end else begin
          cx_r <= cx_r - dx; cy_r <= cy_r + dy; cz_r <= cz_r - at;
        end
        cnt_r <= cnt_r + 1'b1;
      end
      S_CRF: begin
        aroll_r <= zclamp_pi;
        rad_r   <= {item_r.ay2 + item_r.az2, 28'b0};
        rem_r   <= '0;
        root_r  <= '0;
        cnt_r   <= 5'd30;
      end
      S_CPF: begin
        pitch_r <= zclamp_hp;
        m1_r    <= $signed({1'b0, g_r}) * gyro_r;
      end
      S_BL2: m2_r <= $signed({1'b0, ginv}) * aroll_r;
      S_BL3: blend_r <= bsum[41] ? -$signed(br) : $signed(br);
      S_WRAP: begin
        if (blend_r > 26'sd51472) blend_r <= blend_r - 26'sd102944;
        else if (blend_r < -26'sd51472) blend_r <= blend_r + 26'sd102944;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      oroll_r  <= roll_held_r;
      opitch_r <= pitch_r;
      ocls_r   <= cls_r;
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.roll_estimate  = oroll_r;
  assign out_ch.pitch_estimate = opitch_r;
  assign out_ch.gain_class     = ocls_r;

endmodule

FILE: rtl/core/imu_adaptive_complementary_filter_top.sv
// Adaptive complementary roll filter with accel pitch: top level.
// The back end works on one sample at a time: gyro step, one shared sqrt unit (16 + 30
// steps) and one shared CORDIC unit (two passes), gain pick, blend, then angle wrap.
// A new word is taken only when the back end is idle and its last result has moved
// to the output register; an input stage and a queue of 2 sit in front.
// Reset (rst_n low, synchronous): registers to defaults, held roll to zero.
module imu_adaptive_complementary_filter_top #(
  parameter int CORDIC_STEPS = acf_pkg::CORDIC_STEPS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  acf_in_if.sink    in_ch,
  acf_out_if.source out_ch,
  acf_cfg_if.sink   cfg_ch
);

  acf_pkg::acf_cfg_t  cfg_r;
  acf_pkg::acf_item_t f_item, q_item;
  logic push, full, pop, nempty;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period    <= acf_pkg::RST_PERIOD;
      cfg_r.err_lo    <= acf_pkg::RST_ERR_LO;
      cfg_r.err_hi    <= acf_pkg::RST_ERR_HI;
      cfg_r.g_steady  <= acf_pkg::RST_G_STEADY;
      cfg_r.g_middle  <= acf_pkg::RST_G_MIDDLE;
      cfg_r.g_dynamic <= acf_pkg::RST_G_DYN;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        acf_pkg::REG_PERIOD:   cfg_r.period    <= cfg_ch.data;
        acf_pkg::REG_ERR_LO:   cfg_r.err_lo    <= cfg_ch.data[14:0];
        acf_pkg::REG_ERR_HI:   cfg_r.err_hi    <= cfg_ch.data[14:0];
        acf_pkg::REG_G_STEADY: cfg_r.g_steady  <= cfg_ch.data;
        acf_pkg::REG_G_MIDDLE: cfg_r.g_middle  <= cfg_ch.data;
        acf_pkg::REG_G_DYN:    cfg_r.g_dynamic <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  acf_front u_front (
    .clk, .rst_n, .in_ch, .push, .full, .item(f_item)
  );

  acf_fifo #(.DEPTH(acf_pkg::QUEUE_DEPTH)) u_fifo (
    .clk, .rst_n, .push, .wdata(f_item), .full, .pop, .nempty, .rdata(q_item)
  );

  acf_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_nempty(nempty), .q_item, .q_pop(pop), .out_ch
  );

  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.roll_estimate <= 17'sd51472 &&
                      out_ch.roll_estimate >= -17'sd51472))
    else $error("roll out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.pitch_estimate <= 16'sd25736 &&
                      out_ch.pitch_estimate >= -16'sd25736))
    else $error("pitch out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue overflow");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result after reset");

endmodule

FILE: verif/acf_tb_scoreboard.sv
// Scoreboard for the adaptive complementary filter: roll/pitch prediction and result checks.
`timescale 1ns / 100ps
class acf_estimate_board;
  typedef struct {
    logic signed [16:0] roll;
    logic signed [15:0] pitch;
    logic [1:0]         cls;
  } estimate_t;

  estimate_t   pending[$];
  int          errors;
  logic [15:0] period, g_steady, g_middle, g_dyn;
  logic [14:0] err_lo, err_hi;
  longint      roll_now;

  function void reset_state();
    period   = acf_pkg::RST_PERIOD;
    err_lo   = acf_pkg::RST_ERR_LO;
    err_hi   = acf_pkg::RST_ERR_HI;
    g_steady = acf_pkg::RST_G_STEADY;
    g_middle = acf_pkg::RST_G_MIDDLE;
    g_dyn    = acf_pkg::RST_G_DYN;
    roll_now = 0;
    pending.delete();
    errors = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      acf_pkg::REG_PERIOD:   period = val;
      acf_pkg::REG_ERR_LO:   err_lo = val[14:0];
      acf_pkg::REG_ERR_HI:   err_hi = val[14:0];
      acf_pkg::REG_G_STEADY: g_steady = val;
      acf_pkg::REG_G_MIDDLE: g_middle = val;
      acf_pkg::REG_G_DYN:    g_dyn = val;
      default: ;
    endcase
  endfunction

  // divide by 2^s, ties away from zero
  function longint div_round(longint v, int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -(((-v) + half) >>> s);
  endfunction

  function longint root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else
        r >>= 1;
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function longint angle_of(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = acf_pkg::HALF_PI_Z;
      end else begin
        x = -y; y = t; z = -longint'(acf_pkg::HALF_PI_Z);
      end
    end
    for (int i = 0; i < acf_pkg::CORDIC_STEPS_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += acf_pkg::atan_entry(i);
      end else begin
        x -= dx; y += dy; z -= acf_pkg::atan_entry(i);
      end
    end
    z = div_round(z, 10);
    if (z > acf_pkg::PI_Q) z = acf_pkg::PI_Q;
    if (z < -acf_pkg::PI_Q) z = -acf_pkg::PI_Q;
    return z;
  endfunction

  function void note_sample(logic signed [15:0] rate, logic signed [15:0] ax,
                            logic signed [15:0] ay, logic signed [15:0] az);
    longint gyro, acc, err, g, blend, side, p;
    estimate_t e;
    gyro = roll_now + div_round(longint'(rate) * period * acf_pkg::DEG_TO_RAD_Q30, 36);
    acc = angle_of(longint'(ay) * 16384, longint'(az) * 16384);
    side = longint'(ay) * ay + longint'(az) * az;
    err = root(side + longint'(ax) * ax) - acf_pkg::ONE_G;
    if (err < 0) err = -err;
    if (err < err_lo) begin
      e.cls = acf_pkg::CLS_STEADY; g = g_steady;
    end else if (err < err_hi) begin
      e.cls = acf_pkg::CLS_MIDDLE; g = g_middle;
    end else begin
      e.cls = acf_pkg::CLS_DYNAMIC; g = g_dyn;
    end
    blend = div_round(g * gyro + (65536 - g) * acc, 16);
    while (blend > acf_pkg::PI_Q) blend -= acf_pkg::TWO_PI_Q;
    while (blend < -acf_pkg::PI_Q) blend += acf_pkg::TWO_PI_Q;
    roll_now = blend;
    p = angle_of(-longint'(ax) * 16384, root(side << 28));
    if (p > acf_pkg::HALF_PI_Q) p = acf_pkg::HALF_PI_Q;
    if (p < -acf_pkg::HALF_PI_Q) p = -acf_pkg::HALF_PI_Q;
    e.roll = blend[16:0];
    e.pitch = p[15:0];
    pending.push_back(e);
  endfunction

  function void check_result(logic signed [16:0] roll, logic signed [15:0] pitch,
                             logic [1:0] cls);
    estimate_t e;
    if (pending.size() == 0) begin
      $display("%0t: result word with nothing expected: roll %0d pitch %0d class %0d",
               $time, roll, pitch, cls);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (roll !== e.roll) begin
      $display("%0t: roll expected %0d actual %0d", $time, e.roll, roll);
      errors++;
    end
    if (pitch !== e.pitch) begin
      $display("%0t: pitch expected %0d actual %0d", $time, e.pitch, pitch);
      errors++;
    end
    if (cls !== e.cls) begin
      $display("%0t: gain class expected %0d actual %0d", $time, e.cls, cls);
      errors++;
    end
  endfunction
endclass

FILE: verif/tb_top.sv
// Testbench top for the adaptive complementary filter.
`timescale 1ns / 100ps
module tb_top;

  logic clk = 0;
  logic rst_n = 0;
  acf_in_if  in_ch();
  acf_out_if out_ch();
  acf_cfg_if cfg_ch();

  acf_estimate_board board = new();
  bit hold_off;
  int idle_cycles;

  imu_adaptive_complementary_filter_top u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.rate_roll = 0;
    in_ch.accel_fwd = 0;
    in_ch.accel_side = 0;
    in_ch.accel_vert = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = 0;
    cfg_ch.data = 0;
    board.reset_state();
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      board.note_sample(in_ch.rate_roll, in_ch.accel_fwd, in_ch.accel_side,
                        in_ch.accel_vert);
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result(out_ch.roll_estimate, out_ch.pitch_estimate, out_ch.gain_class);
    if (rst_n && cfg_ch.valid && cfg_ch.ready)
      board.write_reg(cfg_ch.index, cfg_ch.data);
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // result side: random stalls plus one long hold-off
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ch.ready <= 0;
        repeat (600) @(negedge clk);
        hold_off = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        out_ch.ready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  task automatic write_reg(acf_pkg::acf_reg_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 0;
  endtask

  task automatic send_sample(logic [15:0] rate, logic [15:0] ax, logic [15:0] ay,
                             logic [15:0] az, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.rate_roll <= rate;
    in_ch.accel_fwd <= ax;
    in_ch.accel_side <= ay;
    in_ch.accel_vert <= az;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // moderate accel on every axis, often a small rate; sometimes full-range words
  task automatic send_random(bit no_gap = 0);
    logic [15:0] r, x, y, z;
    int sel;
    sel = $urandom_range(0, 9);
    r = 16'($urandom);
    if (sel < 6) begin
      x = 16'($urandom_range(0, 16000) - 8000);
      y = 16'($urandom_range(0, 24000) - 12000);
      z = 16'($urandom_range(0, 24000) - 12000);
      if ($urandom_range(0, 1)) r = 16'($urandom_range(0, 2000) - 1000);
    end else begin
      x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
    end
    send_sample(r, x, y, z, no_gap);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: extremes and atan2 corner cases at reset settings
    send_sample(0, 0, 0, 16384);
    send_sample(0, 0, 0, 0);
    send_sample(0, 0, 0, 16'h8000);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_sample(100, 16384, 0, 0);
    send_sample(100, 16'hC000, 0, 0);
    send_sample(16'hFF00, 0, 16384, 0);
    send_sample(16'hFF00, 0, 16'hC000, 0);
    send_sample(0, 0, 16'h8000, 16'hFFFF);
    send_sample(0, 0, 1, 16'hFFFF);
    send_sample(50, 0, 1000, 17500);
    send_sample(50, 0, 1000, 19500);
    send_sample(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    drain();

    // huge gyro steps, full weight on gyro, ignored register index
    write_reg(acf_pkg::REG_PERIOD, 16'hFFFF);
    write_reg(acf_pkg::REG_G_STEADY, 16'hFFFF);
    write_reg(acf_pkg::REG_G_MIDDLE, 16'hFFFF);
    write_reg(acf_pkg::REG_G_DYN, 16'hFFFF);
    write_reg(acf_pkg::acf_reg_t'(3'd7), 16'h1234);
    send_sample(16'h7FFF, 0, 0, 16384);
    send_sample(16'h7FFF, 0, 0, 16384);
    send_sample(16'h8000, 0, 0, 16384);
    send_sample(16'h8000, 100, 200, 300);
    drain();

    // period zero, unordered limits, gain zero, high bits dropped
    write_reg(acf_pkg::REG_PERIOD, 16'h0000);
    write_reg(acf_pkg::REG_ERR_LO, 16'hFFFF);
    write_reg(acf_pkg::REG_ERR_HI, 16'h0000);
    write_reg(acf_pkg::REG_G_STEADY, 16'h0000);
    write_reg(acf_pkg::REG_G_DYN, 16'h0000);
    send_sample(1000, 0, 0, 16384);
    send_sample(1000, 16'h8000, 16'h8000, 0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(acf_pkg::REG_PERIOD, acf_pkg::RST_PERIOD);
          write_reg(acf_pkg::REG_ERR_LO, 16'(acf_pkg::RST_ERR_LO));
          write_reg(acf_pkg::REG_ERR_HI, 16'(acf_pkg::RST_ERR_HI));
          write_reg(acf_pkg::REG_G_STEADY, acf_pkg::RST_G_STEADY);
          write_reg(acf_pkg::REG_G_MIDDLE, acf_pkg::RST_G_MIDDLE);
          write_reg(acf_pkg::REG_G_DYN, acf_pkg::RST_G_DYN);
        end
        default: begin
          write_reg(acf_pkg::REG_PERIOD, 16'($urandom));
          write_reg(acf_pkg::REG_ERR_LO, 16'($urandom_range(0, 4000)));
          write_reg(acf_pkg::REG_ERR_HI, 16'($urandom_range(0, 32767)));
          write_reg(acf_pkg::REG_G_STEADY, 16'($urandom));
          write_reg(acf_pkg::REG_G_MIDDLE, 16'($urandom));
          write_reg(acf_pkg::REG_G_DYN, 16'($urandom));
        end
      endcase
      if (phase == 1) begin
        // back-pressure: result side stops while samples keep coming
        hold_off = 1;
        for (int k = 0; k < 10; k++) send_random(1);
      end
      for (int k = 0; k < 100; k++) send_random();
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end
endmodule

FILE: imu_adaptive_complementary_filter_top.f
rtl/core/acf_pkg.sv
rtl/core/acf_if.sv
rtl/core/acf_front.sv
rtl/core/acf_fifo.sv
rtl/core/acf_back.sv
rtl/core/imu_adaptive_complementary_filter_top.sv
verif/acf_tb_scoreboard.sv
verif/tb_top.sv
